// ===== rtl/core/rmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsp_pkg: shared types and constants of the RMSprop update pipeline
// Register codes and reset values, and the state records that travel down
// the square-root and divider cell chains.
// ----------------------------------------------------------------------------
package rmsp_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgRho  = 2'd0;
  localparam logic [1:0] CfgRate = 2'd1;
  localparam logic [1:0] CfgEps  = 2'd2;

  localparam logic [15:0] RhoReset  = 16'd58982;
  localparam logic [23:0] RateReset = 24'd16777;
  localparam logic [15:0] EpsReset  = 16'd2;

  // chain lengths: one root bit / one quotient bit per cell
  localparam int unsigned SqrtCells = 28;
  localparam int unsigned DivCells  = 57;

  // item state inside the square-root chain
  typedef struct packed {
    logic [31:0] val;   // parameter value
    logic        neg;   // gradient sign
    logic        sat;   // cache clipped
    logic [55:0] num;   // rate * |gradient|
    logic [31:0] nc;    // new cache
    logic [55:0] x;     // radicand, consumed two bits per cell from the top
    logic [31:0] r;     // partial remainder
    logic [27:0] q;     // partial root
  } sq_st_t;

  // item state inside the divider chain
  typedef struct packed {
    logic [31:0] val;
    logic        neg;
    logic        sat;
    logic [31:0] nc;
    logic [28:0] d;     // denominator
    logic [28:0] r;     // partial remainder
    logic [56:0] nq;    // numerator shifting out, quotient shifting in
  } dv_st_t;

endpackage

// ===== rtl/core/rmsp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmsp_sqrt_cell: one step of the restoring square root
// Takes two radicand bits, decides one root bit and hands the item on.
// ----------------------------------------------------------------------------
module rmsp_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rmsp_pkg::sq_st_t st_i,
  output logic            valid_o,
  output rmsp_pkg::sq_st_t st_o
);

  logic             valid_q;
  rmsp_pkg::sq_st_t st_d, st_q;
  logic [31:0]      r_sh;
  logic [31:0]      trial;

  // trial subtract of (4q + 1)
  always_comb begin
    st_d  = st_i;
    r_sh  = {st_i.r[29:0], st_i.x[55:54]};
    trial = {2'b00, st_i.q, 2'b01};
    st_d.x = {st_i.x[53:0], 2'b00};
    if (r_sh >= trial) begin
      st_d.r = r_sh - trial;
      st_d.q = {st_i.q[26:0], 1'b1};
    end else begin
      st_d.r = r_sh;
      st_d.q = {st_i.q[26:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

// ===== rtl/core/rmsp_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmsp_div_cell: one step of the restoring divider
// Brings down one numerator bit and decides one quotient bit.
// ----------------------------------------------------------------------------
module rmsp_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rmsp_pkg::dv_st_t st_i,
  output logic            valid_o,
  output rmsp_pkg::dv_st_t st_o
);

  logic             valid_q;
  rmsp_pkg::dv_st_t st_d, st_q;
  logic [29:0]      r_sh;
  logic [29:0]      diff;

  always_comb begin
    st_d = st_i;
    r_sh = {st_i.r, st_i.nq[56]};
    diff = r_sh - {1'b0, st_i.d};
    if (r_sh >= {1'b0, st_i.d}) begin
      st_d.r  = diff[28:0];
      st_d.nq = {st_i.nq[55:0], 1'b1};
    end else begin
      st_d.r  = r_sh[28:0];
      st_d.nq = {st_i.nq[55:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

// ===== rtl/core/rmsprop_param_update.sv =====
// ----------------------------------------------------------------------------
// rmsprop_param_update: RMSprop update of one parameter element per item
// Cache decay, square root, division and saturated value update in Q8.24.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with param_value_i, gradient_i and
//   sq_cache_i. Output channel: out_valid_o / out_stall_i with new_value_o,
//   new_cache_o and saturated_o. Items are independent; one is taken every
//   cycle while the output is not stalled.
//   The pipeline holds three multiply/accumulate stages, 28 square-root
//   cells (one root bit each), one denominator stage, 57 divider cells (one
//   quotient bit each) and the output register. Throughput is one item
//   per cycle unless the output stalls; the cell chains all advance together.
//   When the receiver stalls a held result, the whole pipeline freezes and
//   in_stall_o rises in the same cycle; nothing is lost or repeated.
//   Reset empties the pipeline and loads rho, rate and epsilon with their
//   defaults. Write rho (0), rate (1) and epsilon (2) through cfg_we_i,
//   cfg_idx_i and cfg_data_i only while the pipeline is empty.
// ----------------------------------------------------------------------------
module rmsprop_param_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] param_value_i,
  input  logic signed [31:0] gradient_i,
  input  logic        [31:0] sq_cache_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_value_o,
  output logic        [31:0] new_cache_o,
  output logic               saturated_o,
  input  logic               cfg_we_i,
  input  logic        [1:0]  cfg_idx_i,
  input  logic        [23:0] cfg_data_i
);

  logic        en;
  logic [15:0] rho_q;
  logic [23:0] rate_q;
  logic [15:0] eps_q;

  // whole pipeline advances unless a held result is stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_q  <= rmsp_pkg::RhoReset;
      rate_q <= rmsp_pkg::RateReset;
      eps_q  <= rmsp_pkg::EpsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmsp_pkg::CfgRho:  rho_q  <= cfg_data_i[15:0];
        rmsp_pkg::CfgRate: rate_q <= cfg_data_i;
        rmsp_pkg::CfgEps:  eps_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // stage 1: magnitude, square, rho*cache, rate*|grad|
  logic        v1_q;
  logic [31:0] val1_q;
  logic        neg1_q;
  logic [46:0] sq1_q;
  logic [47:0] rc1_q;
  logic [55:0] num1_q;
  logic [31:0] mag;
  logic [63:0] sq_full;

  assign mag     = gradient_i[31] ? (~gradient_i + 32'd1) : gradient_i;
  assign sq_full = {32'd0, mag} * {32'd0, mag};

  // stage 2: (1 - rho) * sq in two partial products
  logic        v2_q;
  logic [31:0] val2_q;
  logic        neg2_q;
  logic [47:0] rc2_q;
  logic [55:0] num2_q;
  logic [40:0] phi2_q;
  logic [40:0] plo2_q;
  logic [16:0] w;

  assign w = 17'h10000 - {1'b0, rho_q};

  // stage 3: rounded, saturated cache
  logic        v3_q;
  logic [31:0] val3_q;
  logic        neg3_q;
  logic [55:0] num3_q;
  logic [31:0] nc3_q;
  logic        sat3_q;
  logic [63:0] acc;

  assign acc = {8'd0, rc2_q, 8'd0} + {phi2_q[39:0], 24'd0}
             + {23'd0, plo2_q} + 64'h0080_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val1_q <= param_value_i;
      neg1_q <= gradient_i[31];
      sq1_q  <= sq_full[62:16];
      rc1_q  <= {32'd0, rho_q} * {16'd0, sq_cache_i};
      num1_q <= {32'd0, rate_q} * {24'd0, mag};

      val2_q <= val1_q;
      neg2_q <= neg1_q;
      rc2_q  <= rc1_q;
      num2_q <= num1_q;
      phi2_q <= {24'd0, w} * {18'd0, sq1_q[46:24]};
      plo2_q <= {24'd0, w} * {17'd0, sq1_q[23:0]};

      val3_q <= val2_q;
      neg3_q <= neg2_q;
      num3_q <= num2_q;
      if (|acc[63:56]) begin
        nc3_q  <= 32'hFFFF_FFFF;
        sat3_q <= 1'b1;
      end else begin
        nc3_q  <= acc[55:24];
        sat3_q <= 1'b0;
      end
    end
  end

  // square-root chain over new_cache * 2^24
  logic             sq_v [rmsp_pkg::SqrtCells+1];
  rmsp_pkg::sq_st_t sq_s [rmsp_pkg::SqrtCells+1];

  always_comb begin
    sq_v[0]     = v3_q;
    sq_s[0].val = val3_q;
    sq_s[0].neg = neg3_q;
    sq_s[0].sat = sat3_q;
    sq_s[0].num = num3_q;
    sq_s[0].nc  = nc3_q;
    sq_s[0].x   = {nc3_q, 24'd0};
    sq_s[0].r   = 32'd0;
    sq_s[0].q   = 28'd0;
  end

  for (genvar i = 0; i < rmsp_pkg::SqrtCells; i++) begin : g_sqrt
    rmsp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .st_i    (sq_s[i]),
      .valid_o (sq_v[i+1]),
      .st_o    (sq_s[i+1])
    );
  end

  // denominator and rounded numerator
  logic             v4_q;
  rmsp_pkg::dv_st_t dv4_q;
  rmsp_pkg::sq_st_t sq_end;
  logic [28:0]      den;
  logic [28:0]      den_nz;

  assign sq_end = sq_s[rmsp_pkg::SqrtCells];
  assign den    = {1'b0, sq_end.q} + {13'd0, eps_q};
  assign den_nz = (den == 29'd0) ? 29'd1 : den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= sq_v[rmsp_pkg::SqrtCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv4_q.val <= sq_end.val;
      dv4_q.neg <= sq_end.neg;
      dv4_q.sat <= sq_end.sat;
      dv4_q.nc  <= sq_end.nc;
      dv4_q.d   <= den_nz;
      dv4_q.r   <= 29'd0;
      dv4_q.nq  <= {1'b0, sq_end.num} + {29'd0, den_nz[28:1]};
    end
  end

  // divider chain
  logic             dv_v [rmsp_pkg::DivCells+1];
  rmsp_pkg::dv_st_t dv_s [rmsp_pkg::DivCells+1];

  assign dv_v[0] = v4_q;
  assign dv_s[0] = dv4_q;

  for (genvar i = 0; i < rmsp_pkg::DivCells; i++) begin : g_div
    rmsp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[i]),
      .st_i    (dv_s[i]),
      .valid_o (dv_v[i+1]),
      .st_o    (dv_s[i+1])
    );
  end

  // value update and saturation into the output register
  rmsp_pkg::dv_st_t  dv_end;
  logic signed [58:0] val_x;
  logic signed [58:0] step_x;
  logic signed [58:0] nv;
  logic               out_valid_q;
  logic        [31:0] new_value_q;
  logic        [31:0] new_cache_q;
  logic               saturated_q;

  assign dv_end = dv_s[rmsp_pkg::DivCells];
  assign val_x  = {{27{dv_end.val[31]}}, dv_end.val};
  assign step_x = {2'b00, dv_end.nq};
  assign nv     = dv_end.neg ? (val_x + step_x) : (val_x - step_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v[rmsp_pkg::DivCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_cache_q <= dv_end.nc;
      if (nv > 59'sd2147483647) begin
        new_value_q <= 32'h7FFF_FFFF;
        saturated_q <= 1'b1;
      end else if (nv < -59'sd2147483648) begin
        new_value_q <= 32'h8000_0000;
        saturated_q <= 1'b1;
      end else begin
        new_value_q <= nv[31:0];
        saturated_q <= dv_end.sat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = new_value_q;
  assign new_cache_o = new_cache_q;
  assign saturated_o = saturated_q;

  // a clipped result sits at a range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (new_cache_o == 32'hFFFF_FFFF
      || new_value_o == 32'h7FFF_FFFF || new_value_o == 32'h8000_0000))
    else $error("saturated flag without a clipped result");

  // a stalled result is frozen by the pipeline enable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(new_value_o)
      && $stable(new_cache_o)))
    else $error("result changed while stalled");

  // stage 1 only fills when the pipeline advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !v1_q) |=> !v1_q)
    else $error("item entered while the pipeline was frozen");

endmodule
